// ===== src/jptc_pkg.sv =====
// Shared types and constants of the joint PID torque controller.
package jptc_pkg;

    // Item kinds carried in the input tuser.
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Register addresses on the configuration port.
    localparam logic [2:0] ADDR_CONTROL_MODE = 3'd0;

    // Accumulator of the shared unit: three 31 x 33 bit products summed with headroom.
    localparam int ACC_W     = 66;
    // Multiplier operand width and number of shift-add steps.
    localparam int MPL_W     = 31;
    localparam int MUL_STEPS = 31;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VMUL,
        ST_VDIV,
        ST_PMUL,
        ST_DMUL,
        ST_IMUL,
        ST_FIN
    } t_state;

    // Commands from the sequencer to the shared arithmetic unit.
    typedef struct packed {
        logic load_mul;
        logic load_div;
        logic clr_acc;
    } t_mdctl;

endpackage

// ===== src/joint_pid_torque_controller.sv =====
// Top level of the per-joint PID torque controller.
//
// Input stream (s side): tuser carries the item kind (load gains and target,
// joint sample, clear integrals); tdata carries the joint index, angle, time
// stamp, target and three gains. Output stream (m side): one word per in-range
// joint sample, with the joint and the saturated Q16.16 torque in tdata and the
// torque-valid flag in tuser. Load and clear items produce no output word.
// The APB port holds the control mode register at address 0.
//
// Load, clear and ignored items leave the sequencer idle. A sample is accepted,
// then goes through the velocity product, the serial velocity division
// (NUM_W = 33 + bits of TICKS_PER_SECOND, 53 by default), the three gain
// products and a final step. The velocity product and division are skipped on
// the first sample and on a zero interval, the gain products when control is off.
// All of it runs on one shared shift-add and divide unit; s_tready is low meanwhile.
//
// Reset clears gains, targets, velocities, integrals, first-sample marks and
// the control mode. A finished word waits in the output register; while the
// receiver stalls the next sample may be accepted and worked on, and holds
// in its final step until the output register is free.
module joint_pid_torque_controller
    import jptc_pkg::*;
#(
    parameter int JOINTS           = 8,
    parameter int FRAC_BITS        = 16,
    parameter int TICKS_PER_SECOND = 1000000
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // tdata: joint_index[2:0], joint_angle[34:3], time_stamp[66:35],
    // new_target[98:67], new_prop_gain[129:99], new_int_gain[160:130],
    // new_deriv_gain[191:161]
    input  logic [191:0] i_s_tdata,
    // tuser: opcode[1:0]
    input  logic [1:0]   i_s_tuser,
    // Output stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // tdata: out_joint[2:0], torque[34:3], zero fill[39:35]
    output logic [39:0]  o_m_tdata,
    // tuser: torque_valid[0]
    output logic [0:0]   o_m_tuser,
    // Configuration port
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic [2:0]   i_paddr,
    input  logic [31:0]  i_pwdata,
    output logic [31:0]  o_prdata,
    output logic         o_pready
);

    localparam int JW    = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int TPS_W = $clog2(TICKS_PER_SECOND + 1);
    localparam int NUM_W = 33 + TPS_W;

    // Input fields.
    logic [1:0]         w_op;
    logic [2:0]         w_joint;
    logic signed [31:0] w_angle;
    logic [31:0]        w_time;
    logic signed [31:0] w_target;
    logic [30:0]        w_kp;
    logic [30:0]        w_ki;
    logic [30:0]        w_kd;

    assign w_op     = i_s_tuser;
    assign w_joint  = i_s_tdata[2:0];
    assign w_angle  = i_s_tdata[34:3];
    assign w_time   = i_s_tdata[66:35];
    assign w_target = i_s_tdata[98:67];
    assign w_kp     = i_s_tdata[129:99];
    assign w_ki     = i_s_tdata[160:130];
    assign w_kd     = i_s_tdata[191:161];

    // Per-joint state.
    logic [30:0]        r_kp_tab    [JOINTS];
    logic [30:0]        r_ki_tab    [JOINTS];
    logic [30:0]        r_kd_tab    [JOINTS];
    logic signed [31:0] r_tgt_tab   [JOINTS];
    logic signed [31:0] r_pang_tab  [JOINTS];
    logic [31:0]        r_ptime_tab [JOINTS];
    logic signed [31:0] r_vel_tab   [JOINTS];
    logic signed [31:0] r_int_tab   [JOINTS];
    logic [JOINTS-1:0]  r_seen;
    logic               r_mode;

    // Sequencer and working registers.
    t_state             r_state;
    t_state             n_state;
    logic               r_go;
    logic [JW-1:0]      r_idx;
    logic [2:0]         r_joint;
    logic               r_neg;
    logic [32:0]        r_mag;
    logic [31:0]        r_dt;
    logic signed [32:0] r_err;
    logic signed [31:0] r_integ;
    logic               r_samp_mode;

    // Output register.
    logic               r_out_valid;
    logic [2:0]         r_out_joint;
    logic signed [31:0] r_out_torque;
    logic               r_out_tv;

    // Shared unit interface.
    t_mdctl                  w_ctl;
    logic signed [ACC_W-1:0] w_mcand;
    logic [MPL_W-1:0]        w_mplier;
    logic                    w_busy;
    logic signed [ACC_W-1:0] w_acc;
    logic [NUM_W-1:0]        w_quot;

    // Decode of the word at the input.
    logic               w_accept;
    logic               w_in_range;
    logic [JW-1:0]      w_idx;
    logic               w_seen;
    logic [31:0]        w_dt;
    logic signed [32:0] w_diff;
    logic signed [32:0] w_err;
    logic signed [33:0] w_isum;
    logic signed [31:0] w_inew;
    logic               w_step_done;
    logic               w_out_free;
    logic signed [31:0] w_vel_new;
    logic signed [ACC_W-1:0] w_total;
    logic signed [ACC_W:0]   w_neg_total;
    logic signed [31:0] w_torque;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_in_range = ({2'b00, w_joint} < 5'(JOINTS));
    assign w_idx      = JW'(w_joint);
    assign w_seen     = r_seen[w_idx];
    assign w_dt       = w_time - r_ptime_tab[w_idx];
    assign w_diff     = 33'(w_angle) - 33'(r_pang_tab[w_idx]);
    assign w_err      = 33'(w_angle) - 33'(r_tgt_tab[w_idx]);
    assign w_isum     = 34'(r_int_tab[w_idx]) + 34'(w_err);

    // Saturated integral update.
    always_comb begin
        if (w_isum > 34'(S32_MAX)) begin
            w_inew = S32_MAX;
        end else if (w_isum < 34'(S32_MIN)) begin
            w_inew = S32_MIN;
        end else begin
            w_inew = w_isum[31:0];
        end
    end

    assign w_step_done = r_go && !w_busy;
    assign w_out_free  = !r_out_valid || i_m_tready;

    // Signed, saturated velocity from the unsigned quotient.
    always_comb begin
        if (r_neg) begin
            if ((w_quot[NUM_W-1:32] != '0) || (w_quot[31] && (w_quot[30:0] != '0))) begin
                w_vel_new = S32_MIN;
            end else begin
                w_vel_new = -$signed(w_quot[31:0]);
            end
        end else begin
            if (w_quot[NUM_W-1:31] != '0) begin
                w_vel_new = S32_MAX;
            end else begin
                w_vel_new = $signed(w_quot[31:0]);
            end
        end
    end

    // Floor by the fraction bits, negate and saturate.
    assign w_total     = w_acc >>> FRAC_BITS;
    assign w_neg_total = -((ACC_W + 1)'(w_total));

    always_comb begin
        if (!r_samp_mode) begin
            w_torque = '0;
        end else if (w_neg_total > (ACC_W + 1)'(S32_MAX)) begin
            w_torque = S32_MAX;
        end else if (w_neg_total < (ACC_W + 1)'(S32_MIN)) begin
            w_torque = S32_MIN;
        end else begin
            w_torque = w_neg_total[31:0];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (w_op == OP_SAMPLE) && w_in_range) begin
                    if (w_seen && (w_dt != '0)) begin
                        n_state = ST_VMUL;
                    end else if (r_mode) begin
                        n_state = ST_PMUL;
                    end else begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_VMUL: if (w_step_done) n_state = ST_VDIV;
            ST_VDIV: begin
                if (w_step_done) begin
                    n_state = r_samp_mode ? ST_PMUL : ST_FIN;
                end
            end
            ST_PMUL: if (w_step_done) n_state = ST_DMUL;
            ST_DMUL: if (w_step_done) n_state = ST_IMUL;
            ST_IMUL: if (w_step_done) n_state = ST_FIN;
            ST_FIN:  if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: commands and operands for the shared unit.
    always_comb begin
        w_ctl    = '0;
        w_mcand  = '0;
        w_mplier = '0;
        unique case (r_state)
            ST_VMUL: begin
                w_ctl.load_mul = !r_go;
                w_ctl.clr_acc  = 1'b1;
                w_mcand        = ACC_W'(r_mag);
                w_mplier       = MPL_W'(TICKS_PER_SECOND);
            end
            ST_VDIV: begin
                w_ctl.load_div = !r_go;
            end
            ST_PMUL: begin
                w_ctl.load_mul = !r_go;
                w_ctl.clr_acc  = 1'b1;
                w_mcand        = ACC_W'(r_err);
                w_mplier       = r_kp_tab[r_idx];
            end
            ST_DMUL: begin
                w_ctl.load_mul = !r_go;
                w_mcand        = ACC_W'(r_vel_tab[r_idx]);
                w_mplier       = r_kd_tab[r_idx];
            end
            ST_IMUL: begin
                w_ctl.load_mul = !r_go;
                w_mcand        = ACC_W'(r_integ);
                w_mplier       = r_ki_tab[r_idx];
            end
            default: begin
                w_ctl = '0;
            end
        endcase
    end

    jptc_muldiv #(
        .NUM_W (NUM_W)
    ) u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_mcand  (w_mcand),
        .i_mplier (w_mplier),
        .i_dvd    (w_acc[NUM_W-1:0]),
        .i_dvs    (r_dt),
        .o_busy   (w_busy),
        .o_acc    (w_acc),
        .o_quot   (w_quot)
    );

    // State register and step handshake with the shared unit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_go    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ctl.load_mul || w_ctl.load_div) begin
                r_go <= 1'b1;
            end else if (w_step_done) begin
                r_go <= 1'b0;
            end
        end
    end

    // Working registers latched whenever an item is accepted.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_idx       <= w_idx;
            r_joint     <= w_joint;
            r_neg       <= w_diff[32];
            r_mag       <= w_diff[32] ? 33'(-w_diff) : 33'(w_diff);
            r_dt        <= w_dt;
            r_err       <= w_err;
            r_integ     <= w_inew;
            r_samp_mode <= r_mode;
        end
    end

    // Per-joint tables with a defined reset value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < JOINTS; k++) begin
                r_kp_tab[k]  <= '0;
                r_ki_tab[k]  <= '0;
                r_kd_tab[k]  <= '0;
                r_tgt_tab[k] <= '0;
                r_vel_tab[k] <= '0;
                r_int_tab[k] <= '0;
            end
            r_seen <= '0;
        end else begin
            if (w_accept && (w_op == OP_CLEAR)) begin
                for (int k = 0; k < JOINTS; k++) begin
                    r_int_tab[k] <= '0;
                end
                r_seen <= '0;
            end
            if (w_accept && (w_op == OP_LOAD) && w_in_range) begin
                r_tgt_tab[w_idx] <= w_target;
                r_kp_tab[w_idx]  <= w_kp;
                r_ki_tab[w_idx]  <= w_ki;
                r_kd_tab[w_idx]  <= w_kd;
            end
            if (w_accept && (w_op == OP_SAMPLE) && w_in_range) begin
                r_seen[w_idx] <= 1'b1;
                if (r_mode) begin
                    r_int_tab[w_idx] <= w_inew;
                end
            end
            if ((r_state == ST_VDIV) && w_step_done) begin
                r_vel_tab[r_idx] <= w_vel_new;
            end
        end
    end

    // Previous angle and time; read only after the joint has been sampled.
    always_ff @(posedge i_clk) begin
        if (w_accept && (w_op == OP_SAMPLE) && w_in_range) begin
            r_pang_tab[w_idx]  <= w_angle;
            r_ptime_tab[w_idx] <= w_time;
        end
    end

    // Output register: loaded at the final step, held while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_FIN) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FIN) && w_out_free) begin
            r_out_joint  <= r_joint;
            r_out_torque <= w_torque;
            r_out_tv     <= r_samp_mode;
        end
    end

    // Control mode register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_psel && i_penable && i_pwrite && (i_paddr == ADDR_CONTROL_MODE)) begin
            r_mode <= i_pwdata[0];
        end
    end

    assign o_prdata   = (i_paddr == ADDR_CONTROL_MODE) ? {31'd0, r_mode} : 32'd0;
    assign o_pready   = 1'b1;
    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_torque, r_out_joint};
    assign o_m_tuser  = r_out_tv;

endmodule

// ===== src/jptc_muldiv.sv =====
// Shared serial multiply-accumulate and restoring divide unit.
module jptc_muldiv
    import jptc_pkg::*;
#(
    parameter int NUM_W = 53
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mdctl                  i_ctl,
    input  logic signed [ACC_W-1:0] i_mcand,
    input  logic [MPL_W-1:0]        i_mplier,
    input  logic [NUM_W-1:0]        i_dvd,
    input  logic [31:0]             i_dvs,
    output logic                    o_busy,
    output logic signed [ACC_W-1:0] o_acc,
    output logic [NUM_W-1:0]        o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic                    r_busy;
    logic                    r_div;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] r_mcand;
    logic [MPL_W-1:0]        r_mpl;
    logic [NUM_W-1:0]        r_dvd;
    logic [31:0]             r_rem;
    logic [32:0]             w_trial;
    logic                    w_fit;

    // One restoring division step: bring down the next dividend bit and try the divisor.
    assign w_trial = {r_rem, r_dvd[NUM_W-1]};
    assign w_fit   = (w_trial >= {1'b0, i_dvs});

    // Control of the unit: start on command, count the steps down.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_div  <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.load_mul) begin
            r_busy <= 1'b1;
            r_div  <= 1'b0;
            r_cnt  <= CNT_W'(MUL_STEPS);
        end else if (i_ctl.load_div) begin
            r_busy <= 1'b1;
            r_div  <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath: one add per multiply step, one compare and subtract per divide step.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_mul) begin
            r_mcand <= i_mcand;
            r_mpl   <= i_mplier;
            if (i_ctl.clr_acc) begin
                r_acc <= '0;
            end
        end else if (i_ctl.load_div) begin
            r_dvd <= i_dvd;
            r_rem <= '0;
        end else if (r_busy) begin
            if (r_div) begin
                r_rem <= w_fit ? 32'(w_trial - {1'b0, i_dvs}) : w_trial[31:0];
                r_dvd <= {r_dvd[NUM_W-2:0], w_fit};
            end else begin
                if (r_mpl[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                r_mcand <= r_mcand <<< 1;
                r_mpl   <= r_mpl >> 1;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_acc  = r_acc;
    assign o_quot = r_dvd;

endmodule
